FILE: design/apeval_pkg.sv
package apeval_pkg;

	// Default number of fraction bits on the position and result ports.
	localparam int FRAC_BITS_DEF = 16;

	// Internal fixed point: positions and powers in Q30.
	localparam int QW   = 30;
	localparam int XW   = QW + 1;
	localparam int RADW = 2 * QW + 2;

	// Square root pipeline: one result bit per step, a few steps per stage.
	localparam int SQ_STEPS  = 3;
	localparam int SQ_STAGES = (XW + SQ_STEPS - 1) / SQ_STEPS;

	// Stage numbers along the main pipeline.
	localparam int ST_SQ_END = 1 + SQ_STAGES;
	localparam int ST_TERM   = ST_SQ_END + 1;
	localparam int ST_SUM    = ST_TERM + 1;
	localparam int ST_SCALE  = ST_SUM + 1;
	localparam int ST_PREP   = ST_SCALE + 1;
	localparam int ST_DIV    = ST_PREP + 1;
	localparam int N_STAGES  = ST_DIV + 2;

	// Datapath widths.
	localparam int SUMW = 45;
	localparam int BW   = 37;
	localparam int MBW  = 42;
	localparam int NTW  = 52;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAMBER    = 3'd0,
		REG_POSITION  = 3'd1,
		REG_THICKNESS = 3'd2,
		REG_EDGE      = 3'd3
	} reg_idx_t;

	localparam logic [5:0] THICKNESS_RESET = 6'd12;

	// Thickness polynomial coefficients in ten-thousandths.
	localparam logic signed [13:0] C_SQRT      = 14'sd2969;
	localparam logic signed [13:0] C_X1        = -14'sd1260;
	localparam logic signed [13:0] C_X2        = -14'sd3516;
	localparam logic signed [13:0] C_X3        = 14'sd2843;
	localparam logic signed [13:0] C_X4_OPEN   = -14'sd1015;
	localparam logic signed [13:0] C_X4_CLOSED = -14'sd1036;

	// Thickness divisor 200000 = 64 * 3125; the 3125 part uses a reciprocal.
	localparam int THK_YW  = 28;
	localparam int THK_EW  = 12;
	localparam int THK_RW  = 17;
	localparam logic [THK_EW-1:0] THK_DIV   = 12'd3125;
	localparam logic [THK_RW-1:0] THK_RECIP = 17'((2**28) / 3125);
	localparam logic [NTW-1:0] THK_HALF  = NTW'(100000);
	localparam logic [NTW-1:0] THK_LIMIT = NTW'(64'd13107200000);

	// Camber divisors are 10*d*d and 5*d*d with d in 1..9.
	localparam int CAM_YW = 26;
	localparam int CAM_EW = 10;
	localparam int CAM_RW = 26;

	localparam logic [6:0] DSQ [16] = '{
		7'd0, 7'd1, 7'd4, 7'd9, 7'd16, 7'd25, 7'd36, 7'd49,
		7'd64, 7'd81, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
	};

	localparam logic [CAM_RW-1:0] RECIP_ORD [16] = '{
		26'd0, 26'((2**26) / 10), 26'((2**26) / 40), 26'((2**26) / 90),
		26'((2**26) / 160), 26'((2**26) / 250), 26'((2**26) / 360),
		26'((2**26) / 490), 26'((2**26) / 640), 26'((2**26) / 810),
		26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0
	};

	localparam logic [CAM_RW-1:0] RECIP_GRD [16] = '{
		26'd0, 26'((2**26) / 5), 26'((2**26) / 20), 26'((2**26) / 45),
		26'((2**26) / 80), 26'((2**26) / 125), 26'((2**26) / 180),
		26'((2**26) / 245), 26'((2**26) / 320), 26'((2**26) / 405),
		26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0
	};

	// Powers of the position carried through the root pipeline.
	typedef struct packed {
		logic [XW-1:0] xq;
		logic [XW-1:0] x2;
		logic [XW-1:0] x3;
		logic [XW-1:0] x4;
	} poly_t;

	// Partial square root: remainder and root so far.
	typedef struct packed {
		logic [RADW-1:0] rem;
		logic [XW-1:0]   root;
	} sq_t;

	// Result shaping flags that travel beside the dividers.
	typedef struct packed {
		logic thk_zero;
		logic thk_sat;
		logic ord_zero;
		logic ord_sat;
		logic grd_zero;
		logic grd_sat;
		logic grd_neg;
	} flags_t;

	// Q30 product with round half up.
	function automatic logic [XW-1:0] qmul(input logic [XW-1:0] a, input logic [XW-1:0] b);
		logic [RADW-1:0] pr;
		pr = RADW'(a) * RADW'(b) + (RADW'(1) << (QW - 1));
		return pr[QW+XW-1:QW];
	endfunction

	// One bit of the restoring square root.
	function automatic sq_t sqrt_step(input sq_t a, input int i);
		logic [RADW-1:0] trial;
		sq_t r;
		r = a;
		trial = (RADW'(a.root) << (i + 1)) + (RADW'(1) << (2 * i));
		if (a.rem >= trial) begin
			r.rem = a.rem - trial;
			r.root = a.root | (XW'(1) << i);
		end
		return r;
	endfunction

endpackage

FILE: design/apeval_cdiv.sv
module apeval_cdiv #(
	parameter int YW = 26,
	parameter int EW = 10,
	parameter int RW = 26,
	parameter int K  = 26
) (
	input  logic          clk,
	input  logic [2:0]    load,
	input  logic [YW-1:0] y,
	input  logic [EW-1:0] e,
	input  logic [RW-1:0] r,
	output logic [YW-1:0] q
);
	// Quotient y / e for y below 2**K: reciprocal estimate, then one correction.

	logic [YW+RW-1:0] prod_s1;
	logic [YW-1:0]    y_s1;
	logic [EW-1:0]    e_s1;
	logic [YW-1:0]    q0_s2;
	logic [YW-1:0]    m_s2;
	logic [YW-1:0]    y_s2;
	logic [EW-1:0]    e_s2;
	logic [YW+EW-1:0] m_full;
	logic [YW-1:0]    q0;
	logic [YW-1:0]    rem;

	// Estimate from the reciprocal; it is low by at most one.
	always_ff @(posedge clk) begin
		if (load[0]) begin
			prod_s1 <= (YW+RW)'(y) * (YW+RW)'(r);
			y_s1 <= y;
			e_s1 <= e;
		end
	end

	assign q0 = YW'(prod_s1 >> K);
	assign m_full = (YW+EW)'(q0) * (YW+EW)'(e_s1);

	// Multiply back to find the remainder.
	always_ff @(posedge clk) begin
		if (load[1]) begin
			q0_s2 <= q0;
			m_s2 <= m_full[YW-1:0];
			y_s2 <= y_s1;
			e_s2 <= e_s1;
		end
	end

	assign rem = y_s2 - m_s2;

	// Correct the estimate when the remainder reaches the divisor.
	always_ff @(posedge clk) begin
		if (load[2]) begin
			q <= (rem >= YW'(e_s2)) ? q0_s2 + YW'(1) : q0_s2;
		end
	end

endmodule

FILE: design/airfoil_profile_evaluator_core.sv
// Throughput: one request per cycle unless the output stalls; the root pipeline (11 stages,
// up to 3 bits each) and the three reciprocal dividers are fully pipelined.
// Stall on the output holds each full stage with no empty stage after it; empty stages still fill.
// Reset (arst_n low) empties the pipeline and loads the configuration defaults.
module airfoil_profile_evaluator_core #(
	parameter int FRAC_BITS = apeval_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [apeval_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [apeval_pkg::CFG_DATA_W-1:0]   wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [17:0]                  pos_x,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [15:0]                         half_thickness,
	output logic [15:0]                         camber_ordinate,
	output logic signed [17:0]                  camber_gradient
);
	import apeval_pkg::*;

	localparam int S = QW - FRAC_BITS;

	// Configuration registers.
	logic [3:0] cfg_camber_q;
	logic [3:0] cfg_pos_q;
	logic [5:0] cfg_thick_q;
	logic       cfg_edge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_camber_q <= '0;
			cfg_pos_q <= '0;
			cfg_thick_q <= THICKNESS_RESET;
			cfg_edge_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CAMBER:    cfg_camber_q <= wr_data[3:0];
				REG_POSITION:  cfg_pos_q <= wr_data[3:0];
				REG_THICKNESS: cfg_thick_q <= wr_data[5:0];
				REG_EDGE:      cfg_edge_q <= wr_data[0];
				default:       ;
			endcase
		end
	end

	// Stage valid bits and the load chain: a stage loads when empty or draining.
	logic [N_STAGES:1]   v_q;
	logic [N_STAGES+1:1] load;

	always_comb begin
		load[N_STAGES+1] = !out_stall;
		for (int k = N_STAGES; k >= 1; k--) begin
			load[k] = !v_q[k] || load[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (load[1]) begin
				v_q[1] <= in_valid;
			end
			for (int k = 2; k <= N_STAGES; k++) begin
				if (load[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign in_stall = !load[1];
	assign out_valid = v_q[N_STAGES];

	// Stage 1: clamp the position to [0, 1] and widen it to Q30.
	poly_t poly_s [1:ST_SQ_END];
	sq_t   sqst_s [1:ST_SQ_END];
	logic [XW-1:0] x_clamp;
	logic [XW-1:0] x_wide;

	always_comb begin
		x_clamp = XW'(pos_x[16:0]);
		if (pos_x[17]) begin
			x_clamp = '0;
		end else if (x_clamp > (XW'(1) << FRAC_BITS)) begin
			x_clamp = XW'(1) << FRAC_BITS;
		end
		x_wide = x_clamp << S;
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			poly_s[1] <= '{xq: x_wide, x2: '0, x3: '0, x4: '0};
			sqst_s[1] <= '{rem: {1'b0, x_wide, QW'(0)}, root: '0};
		end
	end

	// Root stages: square root bits, with x^2, x^3, x^4 in the first three.
	for (genvar j = 2; j <= ST_SQ_END; j++) begin : g_root
		sq_t   sq_nx;
		poly_t pl_nx;

		always_comb begin
			sq_nx = sqst_s[j-1];
			for (int s = 0; s < SQ_STEPS; s++) begin
				if (QW - (SQ_STEPS * (j - 2) + s) >= 0) begin
					sq_nx = sqrt_step(sq_nx, QW - (SQ_STEPS * (j - 2) + s));
				end
			end
			pl_nx = poly_s[j-1];
			if (j == 2) begin
				pl_nx.x2 = qmul(poly_s[j-1].xq, poly_s[j-1].xq);
			end
			if (j == 3) begin
				pl_nx.x3 = qmul(poly_s[j-1].x2, poly_s[j-1].xq);
			end
			if (j == 4) begin
				pl_nx.x4 = qmul(poly_s[j-1].x3, poly_s[j-1].xq);
			end
		end

		always_ff @(posedge clk) begin
			if (load[j]) begin
				sqst_s[j] <= sq_nx;
				poly_s[j] <= pl_nx;
			end
		end
	end

	// Term stage: polynomial products and the camber line body.
	logic signed [SUMW-1:0] tsq_s13, t1_s13, t2_s13, t3_s13, t4_s13;
	logic signed [BW-1:0]   body_s13, gnum_s13;
	logic [3:0]             d_s13;
	logic                   sym_s13;
	logic signed [13:0]     a4;
	logic signed [BW-1:0]   bp, bx, bx2;
	logic                   fore;

	always_comb begin
		a4 = cfg_edge_q ? C_X4_CLOSED : C_X4_OPEN;
		bp = BW'(cfg_pos_q);
		bx = BW'(poly_s[ST_SQ_END].xq);
		bx2 = BW'(poly_s[ST_SQ_END].x2);
		fore = (10 * bx) <= (bp <<< QW);
	end

	always_ff @(posedge clk) begin
		if (load[ST_TERM]) begin
			tsq_s13 <= C_SQRT * $signed({1'b0, sqst_s[ST_SQ_END].root});
			t1_s13 <= C_X1 * $signed({1'b0, poly_s[ST_SQ_END].xq});
			t2_s13 <= C_X2 * $signed({1'b0, poly_s[ST_SQ_END].x2});
			t3_s13 <= C_X3 * $signed({1'b0, poly_s[ST_SQ_END].x3});
			t4_s13 <= a4 * $signed({1'b0, poly_s[ST_SQ_END].x4});
			body_s13 <= 2 * bp * bx - 10 * bx2 + (fore ? BW'(0) : ((10 - 2 * bp) <<< QW));
			gnum_s13 <= (bp <<< QW) - 10 * bx;
			d_s13 <= fore ? cfg_pos_q : 4'd10 - cfg_pos_q;
			sym_s13 <= (cfg_camber_q == 4'd0) || (cfg_pos_q == 4'd0) || (cfg_pos_q >= 4'd10);
		end
	end

	// Sum stage: thickness polynomial and camber scaling by the camber digit.
	logic signed [SUMW-1:0] sum_s14;
	logic signed [MBW-1:0]  mbody_s14, mg_s14;
	logic [3:0]             d_s14;
	logic                   sym_s14;

	always_ff @(posedge clk) begin
		if (load[ST_SUM]) begin
			sum_s14 <= tsq_s13 + t1_s13 + t2_s13 + t3_s13 + t4_s13;
			mbody_s14 <= $signed({1'b0, cfg_camber_q}) * body_s13;
			mg_s14 <= $signed({1'b0, cfg_camber_q}) * gnum_s13;
			d_s14 <= d_s13;
			sym_s14 <= sym_s13;
		end
	end

	// Scale stage: thickness times digit, camber rounding and saturation checks.
	logic signed [NTW-1:0] nt_s15;
	logic                  tz_s15;
	logic [CAM_YW-1:0]     yo_s15, yg_s15;
	logic                  oz_s15, os_s15, gz_s15, gs_s15, gn_s15;
	logic [3:0]            d_s15;
	logic signed [MBW:0]   no;
	logic [MBW-1:0]        mag, ng;
	logic [6:0]            dsq;

	always_comb begin
		dsq = DSQ[d_s14];
		no = (MBW+1)'(mbody_s14 >>> S) + (MBW+1)'(5 * dsq);
		mag = mg_s14[MBW-1] ? MBW'(-mg_s14) : MBW'(mg_s14);
		ng = (mag + (MBW'(5 * dsq) << (S - 1))) >> S;
	end

	always_ff @(posedge clk) begin
		if (load[ST_SCALE]) begin
			nt_s15 <= sum_s14 * $signed({1'b0, cfg_thick_q});
			tz_s15 <= sum_s14 <= 0;
			oz_s15 <= sym_s14 || (mbody_s14 <= 0);
			os_s15 <= no >= $signed((MBW+1)'(10 * dsq) << 16);
			yo_s15 <= no[CAM_YW-1:0];
			gz_s15 <= sym_s14;
			gs_s15 <= ng >= (MBW'(5 * dsq) << 17);
			gn_s15 <= mg_s14[MBW-1];
			yg_s15 <= ng[CAM_YW-1:0];
			d_s15 <= d_s14;
		end
	end

	// Prep stage: thickness rounding, divider operands and shaping flags.
	logic signed [NTW-1:0] nth;
	logic [THK_YW-1:0]     yt_s16;
	logic [CAM_YW-1:0]     yo_s16, yg_s16;
	logic [CAM_EW-1:0]     eo_s16, eg_s16;
	logic [CAM_RW-1:0]     ro_s16, rg_s16;
	flags_t                fl_s16, fl_s17, fl_s18, fl_s19;

	assign nth = (nt_s15 >>> S) + $signed(THK_HALF);

	always_ff @(posedge clk) begin
		if (load[ST_PREP]) begin
			yt_s16 <= nth[THK_YW+5:6];
			yo_s16 <= yo_s15;
			yg_s16 <= yg_s15;
			eo_s16 <= CAM_EW'(10 * DSQ[d_s15]);
			eg_s16 <= CAM_EW'(5 * DSQ[d_s15]);
			ro_s16 <= RECIP_ORD[d_s15];
			rg_s16 <= RECIP_GRD[d_s15];
			fl_s16 <= '{thk_zero: tz_s15 || (nt_s15 <= 0),
				thk_sat: nth >= $signed(THK_LIMIT),
				ord_zero: oz_s15, ord_sat: os_s15,
				grd_zero: gz_s15, grd_sat: gs_s15, grd_neg: gn_s15};
		end
	end

	// Flags follow the three divider stages.
	always_ff @(posedge clk) begin
		if (load[ST_DIV]) begin
			fl_s17 <= fl_s16;
		end
		if (load[ST_DIV+1]) begin
			fl_s18 <= fl_s17;
		end
		if (load[ST_DIV+2]) begin
			fl_s19 <= fl_s18;
		end
	end

	// Dividers by constants: the fixed thickness divisor, and camber divisors selected from small tables.
	logic [THK_YW-1:0] qt;
	logic [CAM_YW-1:0] qo, qg;

	apeval_cdiv #(.YW(THK_YW), .EW(THK_EW), .RW(THK_RW), .K(THK_YW)) u_div_thk (
		.clk  (clk),
		.load (load[ST_DIV+2:ST_DIV]),
		.y    (yt_s16),
		.e    (THK_DIV),
		.r    (THK_RECIP),
		.q    (qt)
	);

	apeval_cdiv #(.YW(CAM_YW), .EW(CAM_EW), .RW(CAM_RW), .K(CAM_YW)) u_div_ord (
		.clk  (clk),
		.load (load[ST_DIV+2:ST_DIV]),
		.y    (yo_s16),
		.e    (eo_s16),
		.r    (ro_s16),
		.q    (qo)
	);

	apeval_cdiv #(.YW(CAM_YW), .EW(CAM_EW), .RW(CAM_RW), .K(CAM_YW)) u_div_grd (
		.clk  (clk),
		.load (load[ST_DIV+2:ST_DIV]),
		.y    (yg_s16),
		.e    (eg_s16),
		.r    (rg_s16),
		.q    (qg)
	);

	// Result shaping: zero, saturation and sign.
	always_comb begin
		half_thickness = fl_s19.thk_zero ? 16'd0 : fl_s19.thk_sat ? 16'hFFFF : qt[15:0];
		camber_ordinate = fl_s19.ord_zero ? 16'd0 : fl_s19.ord_sat ? 16'hFFFF : qo[15:0];
		if (fl_s19.grd_zero) begin
			camber_gradient = '0;
		end else if (fl_s19.grd_sat) begin
			camber_gradient = fl_s19.grd_neg ? 18'sh20000 : 18'sh1FFFF;
		end else begin
			camber_gradient = fl_s19.grd_neg ? -$signed(qg[17:0]) : $signed(qg[17:0]);
		end
	end

`ifndef NO_ASSERTIONS
	// The input is held back only when the whole pipeline is blocked at the output.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the pipeline can move");

	// A symmetric section gives no camber line.
	a_symmetric: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((cfg_camber_q == 4'd0) || (cfg_pos_q == 4'd0)))
		|-> (camber_ordinate == 16'd0 && camber_gradient == 18'sd0))
		else $error("camber output on a symmetric section");

	// The finished root never exceeds the square root of its radicand.
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[ST_SQ_END] |-> (RADW'(sqst_s[ST_SQ_END].root) * RADW'(sqst_s[ST_SQ_END].root)
		<= {1'b0, poly_s[ST_SQ_END].xq, QW'(0)}))
		else $error("square root too large");
`endif

endmodule
